FILE: rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants of the sliding window rate meter: word formats,
// history entry, cell operations, register indexes and reset values.
// ----------------------------------------------------------------------------
package swrm_pkg;

    // field widths
    localparam int STAMP_W    = 48;
    localparam int COUNT_W    = 32;
    localparam int BUCKET_W   = 48;
    localparam int SUM_W      = 51;
    localparam int RATE_W     = 61;
    localparam int REG_W      = 16;
    localparam int CFG_INDEX_W = 2;

    // divider sizes
    localparam int DIVIDEND_W  = RATE_W;
    localparam int DIVISOR_W   = REG_W;
    localparam int DIV_STEP_W  = $clog2(DIVIDEND_W);

    // milliseconds per second
    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    // saturation limits
    localparam logic [BUCKET_W-1:0] BUCKET_MAX = {BUCKET_W{1'b1}};
    localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MSEC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUCKET_MSEC = 2'd1;

    // register reset values
    localparam logic [REG_W-1:0] WINDOW_RESET = 16'd2000;
    localparam logic [REG_W-1:0] BUCKET_RESET = 16'd250;

    // input word modes
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // input word
    typedef struct packed {
        logic               mode;
        logic [STAMP_W-1:0] now_msec;
        logic [COUNT_W-1:0] num_bytes;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [SUM_W-1:0]  window_bytes;
        logic [RATE_W-1:0] rate_bytes_per_sec;
    } out_word_t;

    // one history bucket
    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [BUCKET_W-1:0] bytes;
    } entry_t;

    // what a cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_ROTATE,
        CELL_ACCUM
    } cell_op_t;

    // control of one cell
    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

FILE: rtl/swrm_cell.sv
// ----------------------------------------------------------------------------
// swrm_cell
// One bucket of the history chain. Takes its newer neighbor on a push, its
// older neighbor on a rotate, or adds a byte count with saturation.
// ----------------------------------------------------------------------------
module swrm_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  swrm_pkg::cell_ctrl_t         ctrl,
    input  swrm_pkg::entry_t             newer,
    input  swrm_pkg::entry_t             older,
    input  logic [swrm_pkg::COUNT_W-1:0] add_bytes,
    output swrm_pkg::entry_t             entry
);

    swrm_pkg::entry_t                    entry_reg;
    swrm_pkg::entry_t                    entry_next;
    logic [swrm_pkg::BUCKET_W:0]         acc_sum;

    // saturating add of the count
    assign acc_sum = {1'b0, entry_reg.bytes}
                   + (swrm_pkg::BUCKET_W + 1)'(add_bytes);

    // next entry
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            swrm_pkg::CELL_HOLD:   entry_next = entry_reg;
            swrm_pkg::CELL_PUSH:   entry_next = newer;
            swrm_pkg::CELL_ROTATE: entry_next = older;
            swrm_pkg::CELL_ACCUM:
            begin
                entry_next.bytes = acc_sum[swrm_pkg::BUCKET_W]
                                 ? swrm_pkg::BUCKET_MAX
                                 : acc_sum[swrm_pkg::BUCKET_W-1:0];
            end
            default:               entry_next = entry_reg;
        endcase
    end

    // bucket storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div
// Restoring divider, one quotient bit per cycle. Divides the scaled window
// sum by the window length.
// ----------------------------------------------------------------------------
module swrm_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [swrm_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [swrm_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [swrm_pkg::DIVIDEND_W-1:0] quotient
);

    localparam int DW = swrm_pkg::DIVIDEND_W;
    localparam int VW = swrm_pkg::DIVISOR_W;
    localparam int SW = swrm_pkg::DIV_STEP_W;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [DW-1:0] work_reg;
    logic [DW-1:0] work_next;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] divisor_reg;
    logic [VW-1:0] divisor_next;
    logic [VW:0]   trial;
    logic [VW:0]   trial_diff;
    logic          fits;

    // one trial subtraction
    assign trial      = {rem_reg, work_reg[DW-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign fits       = (trial >= {1'b0, divisor_reg});

    // step control
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DW-2:0], fits};
            rem_next  = fits ? trial_diff[VW-1:0] : trial[VW-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                step_next = '0;
            end
        end
    end

    // divider registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

FILE: rtl/sliding_window_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_unit
// Byte-rate meter over a chain of time buckets, with a window sum and a
// bytes-per-second figure on query.
// ----------------------------------------------------------------------------
// Record words (mode 0) update the bucket chain at the accepting edge and a
// zero result word follows. Query words (mode 1) pass through the accepting
// cycle, then ST_WALK, where the chain rotates once all the way round and the
// oldest-ward sum is gathered at cell 0, then ST_MUL, which scales the sum by
// 1000 and starts the bit-serial divider, then ST_DIV, which waits for the
// divider and takes the quotient, and last ST_DONE, which loads the output
// register. A stalled result word holds the sequencer in ST_DONE. One word is
// worked on at a time; a new word is taken while a finished result still
// waits at the output register.
module sliding_window_rate_meter_unit
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  swrm_pkg::in_word_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output swrm_pkg::out_word_t                out_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swrm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [swrm_pkg::REG_W-1:0]         cfg_data
);

    localparam int STEP_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [STEP_W-1:0]                    step_reg;
    logic [STEP_W-1:0]                    step_next;
    logic                                 alive_reg;
    logic                                 alive_next;
    logic [swrm_pkg::STAMP_W-1:0]         cutoff_reg;
    logic [swrm_pkg::STAMP_W-1:0]         cutoff_next;
    logic [swrm_pkg::SUM_W-1:0]           sum_reg;
    logic [swrm_pkg::SUM_W-1:0]           sum_next;
    logic [swrm_pkg::RATE_W-1:0]          rate_reg;
    logic [swrm_pkg::RATE_W-1:0]          rate_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    swrm_pkg::out_word_t                  out_word_reg;
    swrm_pkg::out_word_t                  out_word_next;
    logic [swrm_pkg::REG_W-1:0]           window_reg;
    logic [swrm_pkg::REG_W-1:0]           bucket_reg;

    swrm_pkg::entry_t                     entries [HISTORY_DEPTH];
    swrm_pkg::cell_ctrl_t                 ctrls   [HISTORY_DEPTH];
    swrm_pkg::entry_t                     new_entry;

    logic                                 in_accept;
    logic                                 out_free;
    logic                                 join_newest;
    logic [swrm_pkg::STAMP_W:0]           stamp_reach;
    logic                                 early;
    logic                                 in_window;
    logic [swrm_pkg::SUM_W:0]             sum_add;
    logic                                 div_start;
    logic [swrm_pkg::DIVIDEND_W-1:0]      div_dividend;
    logic [swrm_pkg::DIVISOR_W-1:0]       div_divisor;
    logic                                 div_done;
    logic [swrm_pkg::DIVIDEND_W-1:0]      div_quotient;

    // handshakes
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= swrm_pkg::WINDOW_RESET;
            bucket_reg <= swrm_pkg::BUCKET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                swrm_pkg::CFG_WINDOW_MSEC: window_reg <= cfg_data;
                swrm_pkg::CFG_BUCKET_MSEC: bucket_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // record: join the newest bucket or open a new one
    assign stamp_reach = {1'b0, entries[0].stamp}
                       + (swrm_pkg::STAMP_W + 1)'(bucket_reg);
    assign join_newest = (stamp_reach >= {1'b0, in_word.now_msec});
    assign new_entry.stamp = in_word.now_msec;
    assign new_entry.bytes = swrm_pkg::BUCKET_W'(in_word.num_bytes);

    // query start: window reaching back before time zero
    assign early = (in_word.now_msec < swrm_pkg::STAMP_W'(window_reg));

    // cell operations
    always_comb
    begin
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            ctrls[k].op = swrm_pkg::CELL_HOLD;
            if (state_reg == ST_WALK)
            begin
                ctrls[k].op = swrm_pkg::CELL_ROTATE;
            end
            else if (in_accept && (in_word.mode == swrm_pkg::MODE_RECORD))
            begin
                if (!join_newest)
                begin
                    ctrls[k].op = swrm_pkg::CELL_PUSH;
                end
                else if (k == 0)
                begin
                    ctrls[k].op = swrm_pkg::CELL_ACCUM;
                end
            end
        end
    end

    // bucket chain, newest at cell 0
    for (genvar g = 0; g < HISTORY_DEPTH; g++)
    begin : g_cell
        localparam int OLDER = (g + 1) % HISTORY_DEPTH;
        swrm_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrls[g]),
            .newer      ((g == 0) ? new_entry : entries[(g == 0) ? 0 : g - 1]),
            .older      (entries[OLDER]),
            .add_bytes  (in_word.num_bytes),
            .entry      (entries[g])
        );
    end

    // walk step at cell 0
    assign in_window = alive_reg && (entries[0].stamp > cutoff_reg);
    assign sum_add   = {1'b0, sum_reg} + (swrm_pkg::SUM_W + 1)'(entries[0].bytes);

    // scale and divide
    assign div_start    = (state_reg == ST_MUL);
    assign div_dividend = swrm_pkg::DIVIDEND_W'(sum_reg)
                        * swrm_pkg::DIVIDEND_W'(swrm_pkg::MS_PER_SEC);
    assign div_divisor  = (window_reg == '0) ? swrm_pkg::DIVISOR_W'(1) : window_reg;

    swrm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        alive_next     = alive_reg;
        cutoff_next    = cutoff_reg;
        sum_next       = sum_reg;
        rate_next      = rate_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sum_next  = '0;
                    rate_next = '0;
                    if (in_word.mode == swrm_pkg::MODE_QUERY)
                    begin
                        alive_next  = !early;
                        cutoff_next = in_word.now_msec
                                    - swrm_pkg::STAMP_W'(window_reg);
                        step_next   = '0;
                        state_next  = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                if (in_window)
                begin
                    sum_next = sum_add[swrm_pkg::SUM_W] ? swrm_pkg::SUM_MAX
                             : sum_add[swrm_pkg::SUM_W-1:0];
                end
                else
                begin
                    alive_next = 1'b0;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(HISTORY_DEPTH - 1))
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rate_next  = div_quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                   = 1'b1;
                    out_word_next.window_bytes       = sum_reg;
                    out_word_next.rate_bytes_per_sec = rate_reg;
                    state_next                       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            alive_reg     <= 1'b0;
            cutoff_reg    <= '0;
            sum_reg       <= '0;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            alive_reg     <= alive_next;
            cutoff_reg    <= cutoff_next;
            sum_reg       <= sum_next;
            rate_reg      <= rate_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted word left the sequencer idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WALK) |-> (step_reg == '0))
        else $error("walk counter not parked outside the walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.window_bytes == '0))
            |-> (out_word.rate_bytes_per_sec == '0))
        else $error("nonzero rate for an empty window");

endmodule

FILE: tb/sv/tb_sliding_window_rate_meter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_rate_meter_unit
// Self-checking bench for the sliding window rate meter. A queue-fed driver
// presents record and query words with random gaps while the result side
// stalls at random. A bucket history tracker kept in the bench predicts each
// result word, and the monitor compares every field in order of arrival. The
// run covers reset values, register extremes, zero window and zero span,
// unused register indexes, heavily loaded buckets and long random sequences.
// ----------------------------------------------------------------------------
module tb_sliding_window_rate_meter_unit;

    localparam int HIST_DEPTH    = 8;
    localparam int LIMIT_NS      = 20_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int SAT_RECORDS   = 64;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASE_COUNT   = 8;

    localparam logic [swrm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [swrm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [swrm_pkg::STAMP_W-1:0] STAMP_TOP = '1;
    localparam logic [swrm_pkg::COUNT_W-1:0] COUNT_TOP = '1;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    swrm_pkg::in_word_t       in_word   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    swrm_pkg::out_word_t      out_word;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [swrm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [swrm_pkg::REG_W-1:0]       cfg_data  = '0;

    // bench copy of the meter state and registers
    logic [swrm_pkg::REG_W-1:0]    win_ms  = swrm_pkg::WINDOW_RESET;
    logic [swrm_pkg::REG_W-1:0]    span_ms = swrm_pkg::BUCKET_RESET;
    int unsigned                   hist_newest = 0;
    logic [swrm_pkg::STAMP_W-1:0]  hist_stamp [HIST_DEPTH];
    logic [swrm_pkg::BUCKET_W-1:0] hist_bytes [HIST_DEPTH];

    swrm_pkg::in_word_t  feed_words [$];
    swrm_pkg::out_word_t due_words  [$];

    int errors    = 0;
    int n_records = 0;
    int n_queries = 0;
    int n_checked = 0;
    int n_cfg     = 0;
    bit idle_on   = 1'b1;
    bit in_fire   = 1'b0;
    int in_gap    = 0;
    int stall_left = 0;
    logic [swrm_pkg::STAMP_W-1:0] clock_ms = '0;

    sliding_window_rate_meter_unit #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    // advance the bucket history by one word and return its result word
    function automatic swrm_pkg::out_word_t meter_predict(swrm_pkg::in_word_t w);
        swrm_pkg::out_word_t r;
        logic [63:0] now;
        logic [63:0] acc;
        logic [63:0] sum;
        logic [63:0] cut;
        logic [63:0] div;
        int unsigned idx;
        int          n;
        bit          stop;
        r   = '0;
        now = 64'(w.now_msec);
        idx = hist_newest;
        if (w.mode == swrm_pkg::MODE_RECORD)
        begin
            if (64'(hist_stamp[idx]) + 64'(span_ms) >= now)
            begin
                acc = 64'(hist_bytes[idx]) + 64'(w.num_bytes);
                hist_bytes[idx] = (acc > 64'(swrm_pkg::BUCKET_MAX))
                                ? swrm_pkg::BUCKET_MAX : acc[swrm_pkg::BUCKET_W-1:0];
            end
            else
            begin
                idx = (idx + 1) % HIST_DEPTH;
                hist_newest     = idx;
                hist_stamp[idx] = w.now_msec;
                hist_bytes[idx] = swrm_pkg::BUCKET_W'(w.num_bytes);
            end
        end
        else
        begin
            sum = '0;
            // early cutoff: window reaches before time zero
            if (now >= 64'(win_ms))
            begin
                cut  = now - 64'(win_ms);
                stop = 1'b0;
                for (n = 0; n < HIST_DEPTH; n++)
                begin
                    if (!stop)
                    begin
                        if (64'(hist_stamp[idx]) <= cut)
                            stop = 1'b1;
                        else
                        begin
                            sum = sum + 64'(hist_bytes[idx]);
                            if (sum > 64'(swrm_pkg::SUM_MAX))
                                sum = 64'(swrm_pkg::SUM_MAX);
                            idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
                        end
                    end
                end
            end
            div = (win_ms == '0) ? 64'd1 : 64'(win_ms);
            r.window_bytes       = sum[swrm_pkg::SUM_W-1:0];
            r.rate_bytes_per_sec = swrm_pkg::RATE_W'((sum * 64'(swrm_pkg::MS_PER_SEC)) / div);
        end
        return r;
    endfunction

    // idle length: mostly none, mostly short, a few long
    function automatic int pick_idle(int pct);
        int r;
        if ($urandom_range(0, 99) >= pct)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return int'($urandom_range(1, 3));
        else if (r < 95)
            return int'($urandom_range(4, 15));
        return int'($urandom_range(30, 80));
    endfunction

    function automatic logic [swrm_pkg::STAMP_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [swrm_pkg::COUNT_W-1:0] pick_count();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return $urandom_range(0, 4000);
        else if (r < 85)
            return $urandom;
        else if (r < 93)
            return COUNT_TOP;
        return '0;
    endfunction

    // result check, then input acceptance and prediction
    always @(posedge clk)
    begin : result_check
        swrm_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_words.size() == 0)
            begin
                $display("%0t: result word with none due: window_bytes %0d rate %0d",
                         $time, out_word.window_bytes, out_word.rate_bytes_per_sec);
                errors++;
            end
            else
            begin
                want = due_words.pop_front();
                n_checked++;
                if (out_word.window_bytes !== want.window_bytes)
                begin
                    $display("%0t: window_bytes expected %0d actual %0d",
                             $time, want.window_bytes, out_word.window_bytes);
                    errors++;
                end
                if (out_word.rate_bytes_per_sec !== want.rate_bytes_per_sec)
                begin
                    $display("%0t: rate_bytes_per_sec expected %0d actual %0d",
                             $time, want.rate_bytes_per_sec, out_word.rate_bytes_per_sec);
                    errors++;
                end
            end
        end
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            due_words = {due_words, meter_predict(in_word)};
            if (in_word.mode == swrm_pkg::MODE_QUERY)
                n_queries++;
            else
                n_records++;
        end
    end

    // input driver, fed from the pending word queue
    always @(negedge clk)
    begin : word_feed
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (feed_words.size() > 0)
            begin
                in_word  <= feed_words.pop_front();
                in_valid <= 1'b1;
                in_gap = idle_on ? pick_idle(30) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side stalls
    always @(negedge clk)
    begin : result_stall
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = idle_on ? pick_idle(8) : 0;
        end
    end

    task automatic push_word(logic mode, logic [swrm_pkg::STAMP_W-1:0] now,
                             logic [swrm_pkg::COUNT_W-1:0] count);
        swrm_pkg::in_word_t w;
        w.mode      = mode;
        w.now_msec  = now;
        w.num_bytes = count;
        feed_words = {feed_words, w};
    endtask

    // wait until every pending word is sent and every result has come
    task automatic wait_idle();
        while (feed_words.size() != 0 || in_valid || due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [swrm_pkg::CFG_INDEX_W-1:0] idx,
                             logic [swrm_pkg::REG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == swrm_pkg::CFG_WINDOW_MSEC)
            win_ms = val;
        else if (idx == swrm_pkg::CFG_BUCKET_MSEC)
            span_ms = val;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly advancing timelines, some noise and some backward stamps
    task automatic random_phase(int n_items, bit pause_mid);
        int                           k;
        int                           r;
        int unsigned                  span_eff;
        logic [swrm_pkg::STAMP_W-1:0] stride;
        logic [swrm_pkg::COUNT_W-1:0] cnt;
        for (k = 0; k < n_items; k++)
        begin
            // sender holds off until the meter has drained
            if (pause_mid && k == n_items / 2)
                wait_idle();
            cnt      = pick_count();
            span_eff = (span_ms == '0) ? 32'd2 : 32'(span_ms);
            r        = int'($urandom_range(0, 99));
            if (r < 86)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 55)
                    stride = swrm_pkg::STAMP_W'($urandom_range(0, span_eff));
                else if (r < 90)
                    stride = swrm_pkg::STAMP_W'($urandom_range(span_eff, 3 * span_eff));
                else
                    stride = swrm_pkg::STAMP_W'($urandom_range(0, 2 * win_ms + 2));
                clock_ms = clock_ms + stride;
                if ($urandom_range(0, 99) < 25)
                    push_word(swrm_pkg::MODE_QUERY,
                              clock_ms + swrm_pkg::STAMP_W'($urandom_range(0, 3)), cnt);
                else
                    push_word(swrm_pkg::MODE_RECORD, clock_ms, cnt);
            end
            else if (r < 93)
                push_word(1'($urandom), rand48(), cnt);
            else
                push_word(1'($urandom),
                          clock_ms - swrm_pkg::STAMP_W'($urandom_range(0, 2 * span_eff)),
                          cnt);
        end
    endtask

    // main sequence
    initial
    begin : stimulus
        int                         p;
        int                         k;
        logic [swrm_pkg::REG_W-1:0] win_set  [PHASE_COUNT];
        logic [swrm_pkg::REG_W-1:0] span_set [PHASE_COUNT];
        for (k = 0; k < HIST_DEPTH; k++)
        begin
            hist_stamp[k] = '0;
            hist_bytes[k] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values, bucket join boundary, cutoff edges
        push_word(swrm_pkg::MODE_QUERY,  48'd0,    COUNT_TOP);
        push_word(swrm_pkg::MODE_RECORD, 48'd0,    32'd0);
        push_word(swrm_pkg::MODE_RECORD, 48'd250,  COUNT_TOP);
        push_word(swrm_pkg::MODE_RECORD, 48'd251,  32'd7);
        push_word(swrm_pkg::MODE_QUERY,  48'd1999, 32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd2000, 32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd2250, 32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd2251, 32'd0);
        wait_idle();

        // zero window and zero span, unused indexes ignored
        write_reg(swrm_pkg::CFG_WINDOW_MSEC, 16'd0);
        write_reg(swrm_pkg::CFG_BUCKET_MSEC, 16'd0);
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h0000);
        push_word(swrm_pkg::MODE_RECORD, 48'd251, 32'd4);
        push_word(swrm_pkg::MODE_RECORD, 48'd252, 32'd5);
        push_word(swrm_pkg::MODE_QUERY,  48'd252, 32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd251, COUNT_TOP);
        wait_idle();

        // largest registers, top stamp, backward stamp
        write_reg(swrm_pkg::CFG_WINDOW_MSEC, 16'hFFFF);
        write_reg(swrm_pkg::CFG_BUCKET_MSEC, 16'hFFFF);
        push_word(swrm_pkg::MODE_RECORD, STAMP_TOP,   COUNT_TOP);
        push_word(swrm_pkg::MODE_RECORD, 48'd1,       COUNT_TOP);
        push_word(swrm_pkg::MODE_QUERY,  STAMP_TOP,   32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd65534,   32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd65535,   32'd0);
        wait_idle();

        // smallest nonzero registers
        write_reg(swrm_pkg::CFG_WINDOW_MSEC, 16'd1);
        write_reg(swrm_pkg::CFG_BUCKET_MSEC, 16'd1);
        push_word(swrm_pkg::MODE_RECORD, 48'd1000, 32'd9);
        push_word(swrm_pkg::MODE_QUERY,  48'd0,    32'd0);
        push_word(swrm_pkg::MODE_QUERY,  48'd1,    32'd0);
        wait_idle();

        // one bucket takes many full counts back to back
        write_reg(swrm_pkg::CFG_WINDOW_MSEC, 16'hFFFF);
        write_reg(swrm_pkg::CFG_BUCKET_MSEC, 16'hFFFF);
        idle_on = 1'b0;
        for (k = 0; k < SAT_RECORDS; k++)
            push_word(swrm_pkg::MODE_RECORD, 48'h0000_0100_0000, COUNT_TOP);
        push_word(swrm_pkg::MODE_QUERY, 48'h0000_0100_0001, 32'd0);
        wait_idle();
        idle_on = 1'b1;

        // register settings for the random part
        win_set[0] = swrm_pkg::WINDOW_RESET;  span_set[0] = swrm_pkg::BUCKET_RESET;
        win_set[1] = 16'd1;            span_set[1] = 16'd1;
        win_set[2] = 16'hFFFF;         span_set[2] = 16'hFFFF;
        win_set[3] = 16'd0;            span_set[3] = 16'd0;
        win_set[4] = 16'($urandom);    span_set[4] = 16'($urandom);
        win_set[5] = 16'd100;          span_set[5] = 16'd1000;
        win_set[6] = 16'hFFFF;         span_set[6] = 16'd1;
        win_set[7] = 16'($urandom);    span_set[7] = 16'($urandom);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            write_reg(swrm_pkg::CFG_WINDOW_MSEC, win_set[p]);
            write_reg(swrm_pkg::CFG_BUCKET_MSEC, span_set[p]);
            if (p % 3 == 0)
                write_reg((p % 2 == 0) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom));
            idle_on = (p != 2 && p != 5);
            case (p % 4)
                0: clock_ms = swrm_pkg::STAMP_W'($urandom_range(0, 500));
                1: clock_ms = rand48();
                2: clock_ms = STAMP_TOP - swrm_pkg::STAMP_W'($urandom_range(0, 5000));
                default: clock_ms = clock_ms;
            endcase
            random_phase(PHASE_ITEMS, p == 0 || p == 4);
        end

        // drain and settle
        wait_idle();
        idle_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_words.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, due_words.size());
            errors += due_words.size();
        end

        $display("covered %0d record and %0d query words under %0d register writes",
                 n_records, n_queries, n_cfg);
        $display("%0d result words compared, %0d mismatches", n_checked, errors);
        if (errors == 0)
            $display("** sliding_window_rate_meter_unit: PASSED **");
        else
            $display("** sliding_window_rate_meter_unit: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin : run_limit
        #(LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("** sliding_window_rate_meter_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/swrm_pkg.sv
rtl/swrm_cell.sv
rtl/swrm_div.sv
rtl/sliding_window_rate_meter_unit.sv
tb/sv/tb_sliding_window_rate_meter_unit.sv
